[hdl/cfr_pkg.sv]
`timescale 1ns / 1ps

package cfr_pkg;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_BODY,
    PH_CSUM,
    PH_TAIL
  } phase_t;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_CSUM_BAD  = 2'd1;
  localparam logic [1:0] ST_TAIL_BAD  = 2'd2;
  localparam logic [1:0] ST_TOO_LONG  = 2'd3;

  localparam logic [3:0] CLS_BOARD_INFO  = 4'd0;
  localparam logic [3:0] CLS_REAL1       = 4'd1;
  localparam logic [3:0] CLS_REAL2       = 4'd2;
  localparam logic [3:0] CLS_EVENTS      = 4'd3;
  localparam logic [3:0] CLS_READ_COEFF  = 4'd4;
  localparam logic [3:0] CLS_START_ADJ   = 4'd5;
  localparam logic [3:0] CLS_BAD_MODE    = 4'd6;
  localparam logic [3:0] CLS_WRITE_COEFF = 4'd7;
  localparam logic [3:0] CLS_UNKNOWN     = 4'd8;

  localparam logic [7:0] HDR_BYTE  = 8'hfe;
  localparam logic [7:0] TAIL_BYTE = 8'hfc;

  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] CMD_WRITE = 8'h10;

  localparam logic [15:0] REQ_BOARD_INFO = 16'h0e0e;
  localparam logic [15:0] REQ_REAL1      = 16'h0100;
  localparam logic [15:0] REQ_REAL2      = 16'h0101;
  localparam logic [15:0] REQ_EVENTS     = 16'h0500;
  localparam logic [15:0] REQ_COEFF      = 16'h0200;
  localparam logic [15:0] REQ_START_ADJ  = 16'h0300;

  // frame offsets
  localparam int OFS_BODY    = 4;
  localparam int OFS_CMD     = 5;
  localparam int OFS_REQ_LO  = 6;
  localparam int OFS_REQ_HI  = 7;
  localparam int OFS_LEN_LO  = 8;
  localparam int OFS_LEN_HI  = 9;
  localparam int OFS_TIME    = 18;
  localparam int OFS_MODE    = 26;
  localparam int OFS_CSUM    = 10;
  localparam int TRAILER_LEN = 16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_index;
    logic [7:0]  payload_byte;
    logic [1:0]  frame_status;
    logic [3:0]  request_class;
    logic [31:0] time_stamp;
    logic [2:0]  adjust_mode;
  } cfr_result_t;

endpackage

[hdl/cfr_parser.sv]
`timescale 1ns / 1ps

module cfr_parser #(
  parameter int MAX_FRAME   = 512,
  parameter int COEFF_BYTES = 176
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  output cfr_pkg::cfr_result_t res,
  output logic                res_valid
);
  import cfr_pkg::*;

  localparam int PW = $clog2(MAX_FRAME + 1);
  localparam int CW = 18;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  header_run_r, header_run_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [15:0] frame_end_r, frame_end_nxt;
  logic [15:0] running_sum_r, running_sum_nxt;
  logic [7:0]  command_r, command_nxt;
  logic [15:0] request_r, request_nxt;
  logic [31:0] time_r, time_nxt;
  logic [31:0] mode_r, mode_nxt;
  logic [15:0] recv_sum_r, recv_sum_nxt;
  logic [1:0]  tail_run_r, tail_run_nxt;

  logic [CW-1:0] pos_w;
  logic [CW-1:0] csum_pos_w;
  logic [4:0]    lane_shift;
  logic [PW-1:0] pos_inc;

  function automatic logic [3:0] classify(input logic [7:0] cmd, input logic [15:0] req,
                                          input logic [31:0] mode);
    logic [3:0] cls;
    cls = CLS_UNKNOWN;
    if (cmd == CMD_READ) begin
      unique case (req)
        REQ_BOARD_INFO: cls = CLS_BOARD_INFO;
        REQ_REAL1:      cls = CLS_REAL1;
        REQ_REAL2:      cls = CLS_REAL2;
        REQ_EVENTS:     cls = CLS_EVENTS;
        REQ_COEFF:      cls = CLS_READ_COEFF;
        default:        cls = CLS_UNKNOWN;
      endcase
    end else if (cmd == CMD_WRITE) begin
      if (req == REQ_START_ADJ) begin
        cls = (mode >= 32'd1 && mode <= 32'd4) ? CLS_START_ADJ : CLS_BAD_MODE;
      end else if (req == REQ_COEFF) begin
        cls = CLS_WRITE_COEFF;
      end
    end
    return cls;
  endfunction

  function automatic cfr_result_t make_verdict(input logic [1:0] status, input logic [3:0] cls,
                                               input logic [31:0] tw, input logic [31:0] mw);
    cfr_result_t r;
    r = '0;
    r.kind          = KIND_VERDICT;
    r.frame_status  = status;
    r.request_class = cls;
    r.time_stamp    = (status == ST_OK) ? tw : 32'd0;
    r.adjust_mode   = (cls == CLS_START_ADJ) ? mw[2:0] : 3'd0;
    return r;
  endfunction

  assign pos_w      = CW'(pos_r);
  assign csum_pos_w = CW'(frame_end_r) + CW'(OFS_CSUM);
  assign pos_inc    = pos_r + PW'(1);
  // time and mode fields both start at an offset of 2 mod 4
  assign lane_shift = {pos_r[1:0] - 2'd2, 3'b000};

  always_comb begin
    phase_nxt       = phase_r;
    header_run_nxt  = header_run_r;
    pos_nxt         = pos_r;
    frame_end_nxt   = frame_end_r;
    running_sum_nxt = running_sum_r;
    command_nxt     = command_r;
    request_nxt     = request_r;
    time_nxt        = time_r;
    mode_nxt        = mode_r;
    recv_sum_nxt    = recv_sum_r;
    tail_run_nxt    = tail_run_r;
    res             = '0;
    res_valid       = 1'b0;

    unique case (phase_r)
      PH_HUNT: begin
        if (rx_byte == HDR_BYTE) begin
          if (header_run_r == 2'd3) begin
            phase_nxt       = PH_BODY;
            header_run_nxt  = 2'd0;
            pos_nxt         = PW'(OFS_BODY);
            running_sum_nxt = 16'(4 * 32'hfe);
            frame_end_nxt   = '0;
            command_nxt     = '0;
            request_nxt     = '0;
            time_nxt        = '0;
            mode_nxt        = '0;
            recv_sum_nxt    = '0;
            tail_run_nxt    = '0;
          end else begin
            header_run_nxt = header_run_r + 2'd1;
          end
        end else begin
          header_run_nxt = 2'd0;
        end
      end

      PH_BODY: begin
        running_sum_nxt = running_sum_r + {8'h00, rx_byte};
        if (pos_w == CW'(OFS_CMD))         command_nxt = rx_byte;
        else if (pos_w == CW'(OFS_REQ_LO)) request_nxt = {8'h00, rx_byte};
        else if (pos_w == CW'(OFS_REQ_HI)) request_nxt = {rx_byte, request_r[7:0]};
        else if (pos_w == CW'(OFS_LEN_LO)) frame_end_nxt = {8'h00, rx_byte};
        else if (pos_w == CW'(OFS_LEN_HI)) frame_end_nxt = {rx_byte, frame_end_r[7:0]};

        if (pos_w >= CW'(OFS_TIME) && pos_w <= CW'(OFS_TIME + 3))
          time_nxt = time_r | ({24'h0, rx_byte} << lane_shift);
        if (pos_w >= CW'(OFS_MODE) && pos_w <= CW'(OFS_MODE + 3))
          mode_nxt = mode_r | ({24'h0, rx_byte} << lane_shift);

        if (command_r == CMD_WRITE && request_r == REQ_COEFF &&
            pos_w >= CW'(OFS_MODE) && pos_w < CW'(OFS_MODE + COEFF_BYTES)) begin
          res.kind          = KIND_PAYLOAD;
          res.payload_index = 8'(pos_w - CW'(OFS_MODE));
          res.payload_byte  = rx_byte;
          res_valid         = 1'b1;
        end

        if (pos_w == CW'(OFS_LEN_HI) &&
            CW'(frame_end_nxt) + CW'(TRAILER_LEN) > CW'(MAX_FRAME)) begin
          // mode not yet seen, so a start-adjust request reports bad mode
          res       = make_verdict(ST_TOO_LONG, classify(command_r, request_r, mode_r),
                                   time_r, mode_r);
          res_valid      = 1'b1;
          phase_nxt      = PH_HUNT;
          header_run_nxt = 2'd0;
        end else begin
          pos_nxt = pos_inc;
          if (pos_w >= CW'(OFS_LEN_HI) &&
              CW'(pos_inc) >= CW'(frame_end_nxt) + CW'(OFS_CSUM))
            phase_nxt = PH_CSUM;
        end
      end

      PH_CSUM: begin
        if (pos_w == csum_pos_w) begin
          recv_sum_nxt = {8'h00, rx_byte};
        end else begin
          recv_sum_nxt = {rx_byte, recv_sum_r[7:0]};
          phase_nxt    = PH_TAIL;
          tail_run_nxt = 2'd0;
        end
        pos_nxt = pos_inc;
      end

      PH_TAIL: begin
        if (rx_byte != TAIL_BYTE) begin
          res = make_verdict(ST_TAIL_BAD, classify(command_r, request_r, mode_r),
                             time_r, mode_r);
          res_valid      = 1'b1;
          phase_nxt      = PH_HUNT;
          // a header byte here opens the next hunt
          header_run_nxt = (rx_byte == HDR_BYTE) ? 2'd1 : 2'd0;
        end else begin
          pos_nxt = pos_inc;
          if (tail_run_r == 2'd3) begin
            res = make_verdict((recv_sum_r == running_sum_r) ? ST_OK : ST_CSUM_BAD,
                               classify(command_r, request_r, mode_r), time_r, mode_r);
            res_valid      = 1'b1;
            phase_nxt      = PH_HUNT;
            header_run_nxt = 2'd0;
            tail_run_nxt   = 2'd0;
          end else begin
            tail_run_nxt = tail_run_r + 2'd1;
          end
        end
      end

      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT;
      header_run_r  <= '0;
      pos_r         <= '0;
      frame_end_r   <= '0;
      running_sum_r <= '0;
      command_r     <= '0;
      request_r     <= '0;
      time_r        <= '0;
      mode_r        <= '0;
      recv_sum_r    <= '0;
      tail_run_r    <= '0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      header_run_r  <= header_run_nxt;
      pos_r         <= pos_nxt;
      frame_end_r   <= frame_end_nxt;
      running_sum_r <= running_sum_nxt;
      command_r     <= command_nxt;
      request_r     <= request_nxt;
      time_r        <= time_nxt;
      mode_r        <= mode_nxt;
      recv_sum_r    <= recv_sum_nxt;
      tail_run_r    <= tail_run_nxt;
    end
  end

endmodule

[hdl/command_frame_receiver_top.sv]
`timescale 1ns / 1ps
// path: each byte is held in the input register, and its result is held in the result register
// throughput: one byte per cycle while out_ready is high; the per-byte parser update
// between the two registers sets this figure
// a byte that closes no payload position or frame produces no result transfer
// reset: synchronous active-low rst_n returns the parser to header hunting, both stages empty

module command_frame_receiver_top #(
  parameter int MAX_FRAME   = 512,
  parameter int COEFF_BYTES = 176
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload_index,
  output logic [7:0]  out_payload_byte,
  output logic [1:0]  out_frame_status,
  output logic [3:0]  out_request_class,
  output logic [31:0] out_time_stamp,
  output logic [2:0]  out_adjust_mode
);
  import cfr_pkg::*;

  logic        in_valid_r, in_valid_nxt;
  logic [7:0]  in_byte_r;
  logic        out_valid_r, out_valid_nxt;
  cfr_result_t out_res_r;
  cfr_result_t res;
  logic        res_valid;
  logic        advance;

  // the held byte moves on once the result slot is free or draining
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  cfr_parser #(
    .MAX_FRAME   (MAX_FRAME),
    .COEFF_BYTES (COEFF_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .rx_byte   (in_byte_r),
    .res       (res),
    .res_valid (res_valid)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_ready) in_valid_nxt = in_valid;

    out_valid_nxt = out_valid_r;
    if (advance) out_valid_nxt = res_valid;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_byte_r <= in_rx_byte;
    if (advance && res_valid) out_res_r <= res;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_res_r.kind;
  assign out_payload_index = out_res_r.payload_index;
  assign out_payload_byte  = out_res_r.payload_byte;
  assign out_frame_status  = out_res_r.frame_status;
  assign out_request_class = out_res_r.request_class;
  assign out_time_stamp    = out_res_r.time_stamp;
  assign out_adjust_mode   = out_res_r.adjust_mode;

  a_no_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_kind == KIND_PAYLOAD || out_kind == KIND_VERDICT))
    else $error("result transfer without a kind");

  a_held_byte_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> (in_valid_r && $stable(in_byte_r)))
    else $error("held byte lost while result slot blocked");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind == KIND_PAYLOAD) |->
      (out_frame_status == ST_OK && out_request_class == CLS_BOARD_INFO &&
       out_time_stamp == 32'd0 && out_adjust_mode == 3'd0))
    else $error("payload result carries verdict fields");

  a_time_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind == KIND_VERDICT && out_frame_status != ST_OK) |->
      (out_time_stamp == 32'd0))
    else $error("time stamp given on a failed frame");

endmodule
